// File: hdl/swm_pkg.sv
// Shared types and constants for the sliding window maximum block.
`default_nettype none

package swm_pkg;

	localparam int SAMPLE_W       = 32;
	localparam int WLEN_W         = 7;
	localparam int WINDOW_MAX_DEF = 64;
	localparam int PADDR_W        = 3;
	localparam int PDATA_W        = 32;

	localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd1;

	// Register index is paddr[2]: one register, index 1 lies beyond the map.
	localparam logic REG_WINDOW_LENGTH = 1'b0;

	typedef enum logic [2:0] {
		CMD_HOLD,
		CMD_AGE,
		CMD_SHIFT,
		CMD_INSERT,
		CMD_CLEAR
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t                    cmd;
		logic signed [SAMPLE_W-1:0]   sample;
	} cell_ctrl_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} swm_state_t;

endpackage

`default_nettype wire

// File: hdl/swm_cell.sv
// One queue cell: holds a candidate value, its age and a valid bit.
`default_nettype none

module swm_cell #(
	parameter int AGE_W   = 7,
	parameter int AGE_MAX = 64,
	parameter bit TAIL    = 1'b0
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  swm_pkg::cell_ctrl_t                ctrl,
	input  logic signed [swm_pkg::SAMPLE_W-1:0] nxt_value,
	input  logic [AGE_W-1:0]                   nxt_age,
	input  logic                               nxt_valid,
	input  logic                               prev_kept,
	output logic signed [swm_pkg::SAMPLE_W-1:0] value,
	output logic [AGE_W-1:0]                   age,
	output logic                               valid,
	output logic                               kept
);
	import swm_pkg::*;

	logic signed [SAMPLE_W-1:0] value_q;
	logic [AGE_W-1:0]           age_q;
	logic                       valid_q;
	logic                       take;
	logic [AGE_W-1:0]           age_inc;

	// A candidate survives the insert only if it is strictly above the new sample.
	assign kept = valid_q && (value_q > ctrl.sample);
	// The new sample lands right behind the last surviving candidate.
	assign take = TAIL ? prev_kept : (prev_kept && !kept);
	assign age_inc = (age_q == AGE_W'(AGE_MAX)) ? age_q : age_q + AGE_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (ctrl.cmd)
				CMD_SHIFT:  valid_q <= nxt_valid;
				CMD_INSERT: valid_q <= kept || take;
				CMD_CLEAR:  valid_q <= 1'b0;
				default:    valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.cmd)
			CMD_AGE: begin
				age_q <= age_inc;
			end
			CMD_SHIFT: begin
				value_q <= nxt_value;
				age_q   <= nxt_age;
			end
			CMD_INSERT: begin
				if (take) begin
					value_q <= ctrl.sample;
					age_q   <= '0;
				end
			end
			default: begin
				value_q <= value_q;
			end
		endcase
	end

	assign value = value_q;
	assign age   = age_q;
	assign valid = valid_q;

endmodule

`default_nettype wire

// File: hdl/swm_regs.sv
// APB-style configuration register file holding the window length.
`default_nettype none

module swm_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [swm_pkg::PADDR_W-1:0]   paddr,
	input  logic [swm_pkg::PDATA_W-1:0]   pwdata,
	output logic [swm_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output logic [swm_pkg::WLEN_W-1:0]    window_length
);
	import swm_pkg::*;

	logic [WLEN_W-1:0] wlen_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_WINDOW_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= WLEN_RESET;
		end else if (wr_en) begin
			wlen_q <= pwdata[WLEN_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_WINDOW_LENGTH) ?
		{{(PDATA_W-WLEN_W){1'b0}}, wlen_q} : '0;
	assign window_length = wlen_q;

endmodule

`default_nettype wire

// File: hdl/sliding_window_max.sv
// Sliding window maximum: a chain of queue cells kept in decreasing order, oldest
// candidate at cell 0, so the window maximum is always read from the head cell.
// A sample needs d shift steps, where d is the number of candidates that age out
// of the window at the head: d is 0 or 1 while the window length stays fixed and
// can be larger right after the length is shrunk. A first step accepts the
// sample and ages every cell, then the chain shifts one cell per cycle while the
// head is too old, and a final step discards the candidates not above the new
// sample and appends it, all cells comparing in parallel. That final step waits
// while a result is due and the previous one still sits in the output register.
// The output register lets the next sample be accepted while a result waits.
// A zero window length acts as one; lengths above WINDOW_MAX act as WINDOW_MAX.
`default_nettype none

module sliding_window_max #(
	parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [swm_pkg::SAMPLE_W-1:0] sample,
	input  logic                                last_sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [swm_pkg::SAMPLE_W-1:0] window_max,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [swm_pkg::PADDR_W-1:0]         paddr,
	input  logic [swm_pkg::PDATA_W-1:0]         pwdata,
	output logic [swm_pkg::PDATA_W-1:0]         prdata,
	output logic                                pready
);
	import swm_pkg::*;

	localparam int LW = $clog2(WINDOW_MAX + 1);
	localparam int CW = (LW > WLEN_W) ? LW : WLEN_W;

	logic [WLEN_W-1:0] wlen;
	logic [CW-1:0]     wlen_ext;
	logic [LW-1:0]     len;

	swm_state_t state_q, state_d;
	cell_ctrl_t ctrl;

	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       last_q;
	logic [LW-1:0]              fill_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] window_max_q;

	logic signed [SAMPLE_W-1:0] cell_value [WINDOW_MAX];
	logic [LW-1:0]              cell_age   [WINDOW_MAX];
	logic                       cell_valid [WINDOW_MAX];
	logic                       cell_kept  [WINDOW_MAX];

	logic accept, finish, produce, head_old, out_load;
	logic signed [SAMPLE_W-1:0] head_next;

	swm_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.window_length (wlen)
	);

	assign wlen_ext = CW'(wlen);
	always_comb begin
		if (wlen == '0) begin
			len = LW'(1);
		end else if (wlen_ext > CW'(WINDOW_MAX)) begin
			len = LW'(WINDOW_MAX);
		end else begin
			len = wlen_ext[LW-1:0];
		end
	end

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		logic signed [SAMPLE_W-1:0] n_value;
		logic [LW-1:0]              n_age;
		logic                       n_valid;
		logic                       p_kept;

		if (i == WINDOW_MAX - 1) begin : g_tail
			assign n_value = '0;
			assign n_age   = '0;
			assign n_valid = 1'b0;
		end else begin : g_body
			assign n_value = cell_value[i+1];
			assign n_age   = cell_age[i+1];
			assign n_valid = cell_valid[i+1];
		end

		if (i == 0) begin : g_head
			assign p_kept = 1'b1;
		end else begin : g_link
			assign p_kept = cell_kept[i-1];
		end

		swm_cell #(
			.AGE_W   (LW),
			.AGE_MAX (WINDOW_MAX),
			.TAIL    (i == WINDOW_MAX - 1)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.nxt_value (n_value),
			.nxt_age   (n_age),
			.nxt_valid (n_valid),
			.prev_kept (p_kept),
			.value     (cell_value[i]),
			.age       (cell_age[i]),
			.valid     (cell_valid[i]),
			.kept      (cell_kept[i])
		);
	end

	assign head_old  = cell_valid[0] && (cell_age[0] >= len);
	assign produce   = (fill_q >= len);
	assign head_next = cell_kept[0] ? cell_value[0] : sample_q;
	assign accept    = in_valid && in_ready;

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		finish      = 1'b0;
		out_load    = 1'b0;
		ctrl.cmd    = CMD_HOLD;
		ctrl.sample = sample_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctrl.cmd = CMD_AGE;
					state_d  = ST_RUN;
				end
			end
			ST_RUN: begin
				if (head_old) begin
					// drop the head, it has left the window
					ctrl.cmd = CMD_SHIFT;
				end else if (!(produce && out_valid_q && !out_ready)) begin
					ctrl.cmd = last_q ? CMD_CLEAR : CMD_INSERT;
					finish   = 1'b1;
					out_load = produce;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			if (fill_q != LW'(WINDOW_MAX)) begin
				fill_q <= fill_q + LW'(1);
			end
		end else if (finish && last_q) begin
			fill_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample;
			last_q   <= last_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			window_max_q <= head_next;
		end
	end

	assign out_valid  = out_valid_q;
	assign window_max = window_max_q;

endmodule

`default_nettype wire

// File: hdl/swm_checker.sv
// Port-level checks for the sliding window maximum block, bound to its top level.
`default_nettype none

module swm_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [swm_pkg::SAMPLE_W-1:0] window_max,
	input logic                                pready
);

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(window_max))
		else $error("result changed or vanished while stalled");

	// One sample at a time: a transaction closes the input until it is done.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted again while a sample is in flight");

	// A new result shows up as the block returns to idle.
	a_result_at_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result raised while a sample is still in flight");

	// The configuration port never inserts wait states.
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

endmodule

bind sliding_window_max swm_checker u_swm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.window_max (window_max),
	.pready     (pready)
);

`default_nettype wire
